// ----- hdl/ibb_pkg.sv -----
// ----------------------------------------------------------------------------
// ibb_pkg
// Shared constants, register codes and clamp helpers for the pixel binning
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package ibb_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_BIN      = 8;
	localparam int PIXEL_BITS   = 16;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
	localparam int DIM_W  = 13;
	localparam int NB_W   = 4;
	localparam int XI_W   = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
	localparam int RP_W   = 19;
	localparam int SUM_W  = 22;
	localparam int IDX_W  = 12;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [CIDX_W-1:0] {
		REG_RAW_WIDTH  = 2'd0,
		REG_RAW_HEIGHT = 2'd1,
		REG_BIN_FACTOR = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [COL_W-1:0] addr;
		logic [RP_W-1:0]  row_sum;
		logic             col_op;
		logic             first_row;
		logic             blk_done;
		logic             last_blk;
		logic [IDX_W-1:0] bx;
		logic [IDX_W-1:0] by;
	} ibb_stage_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > limit)
			r = limit;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [NB_W-1:0] clamp_bin(input logic [NB_W-1:0] v);
		logic [NB_W-1:0] r;
		if (v == '0)
			r = NB_W'(1);
		else if (v > NB_W'(MAX_BIN))
			r = NB_W'(MAX_BIN);
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/image_block_binning.sv -----
// ----------------------------------------------------------------------------
// image_block_binning
// Sums each bin_factor by bin_factor block of a raster pixel stream into one
// output pixel, using a line store of per-column partial sums.
// ----------------------------------------------------------------------------
//  channel   direction  transfer on          payload
//  s_*       in         s_tvalid & s_tready  pixel_value
//  m_*       out        m_tvalid & m_tready  bin_sum, out_column, out_row, tlast
//  cfg_*     in         cfg_we               raw_width, raw_height, bin_factor
//
//  one pixel per cycle unless a stalled output backs up; a block sum passes the add
//  stage and output register (line store read at accept, add and write back in the add stage)
//  a stalled output holds the add stage; input stalls only when both are full
//  back-to-back hits on one store entry are served by forwarding the last sum
//  reset clears counters and valids; the line store needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module image_block_binning
	import ibb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // pixel_value
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // bin_sum, out_column, out_row, zero fill
	output logic                        m_tlast,   // frame_end
	input  wire logic                   cfg_we,
	input  wire logic [CIDX_W-1:0]      cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	logic [DIM_W-1:0] raw_width_q, raw_height_q;
	logic [NB_W-1:0]  bin_factor_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [XI_W-1:0]  xi_q, yi_q;
	logic [IDX_W-1:0] bx_q, by_q;
	logic [DIM_W-1:0] col_end_q, row_end_q;
	logic [RP_W-1:0]  row_partial_q;

	logic [SUM_W-1:0] mem [MAX_WIDTH];
	logic [SUM_W-1:0] rd_s1;
	logic             s1_valid_q;
	ibb_stage_t       s1_q;
	logic             fwd_s1;
	logic [SUM_W-1:0] fwd_data_q;

	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic [IDX_W-1:0] out_col_q, out_row_q;
	logic             out_last_q;

	logic [DIM_W-1:0] w, h;
	logic [NB_W-1:0]  nb, nb_new;
	logic             accept, s1_go, out_free;
	logic             in_x, in_y, col_op, blk_done, last_blk, last_x, last_y;
	logic             xi_last, yi_last;
	logic [RP_W-1:0]  rp_next;
	logic [SUM_W-1:0] base, acc;
	logic [PIXEL_BITS-1:0] pix;

	assign w   = clamp_dim(raw_width_q, DIM_W'(MAX_WIDTH));
	assign h   = clamp_dim(raw_height_q, DIM_W'(HEIGHT_LIMIT));
	assign nb  = clamp_bin(bin_factor_q);
	assign pix = s_tdata[PIXEL_BITS-1:0];

	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = s1_valid_q && (!s1_q.blk_done || out_free);
	assign s_tready = !s1_valid_q || s1_go;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_x     = col_end_q <= w;
		in_y     = row_end_q <= h;
		xi_last  = {{(NB_W-XI_W){1'b0}}, xi_q} == nb - NB_W'(1);
		yi_last  = {{(NB_W-XI_W){1'b0}}, yi_q} == nb - NB_W'(1);
		col_op   = in_x && in_y && xi_last;
		blk_done = col_op && yi_last;
		last_blk = (col_end_q + DIM_W'(nb) > w) && (row_end_q + DIM_W'(nb) > h);
		last_x   = {1'b0, col_q} + DIM_W'(1) >= w;
		last_y   = {1'b0, row_q} + DIM_W'(1) >= h;
		rp_next  = ((xi_q == '0) ? '0 : row_partial_q) + RP_W'(pix);
	end

	// nb after a pending config write, for the restart values
	always_comb begin
		nb_new = nb;
		if (cfg_we && cfg_index == REG_BIN_FACTOR)
			nb_new = clamp_bin(cfg_data[NB_W-1:0]);
	end

	// configuration and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_width_q   <= DIM_W'(MAX_WIDTH);
			raw_height_q  <= DIM_W'(HEIGHT_LIMIT);
			bin_factor_q  <= NB_W'(1);
			col_q         <= '0;
			row_q         <= '0;
			xi_q          <= '0;
			yi_q          <= '0;
			bx_q          <= '0;
			by_q          <= '0;
			col_end_q     <= DIM_W'(1);
			row_end_q     <= DIM_W'(1);
			row_partial_q <= '0;
		end else if (cfg_we && cfg_index <= REG_BIN_FACTOR) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RAW_WIDTH:  raw_width_q  <= cfg_data;
				REG_RAW_HEIGHT: raw_height_q <= cfg_data;
				REG_BIN_FACTOR: bin_factor_q <= cfg_data[NB_W-1:0];
				default: ;
			endcase
			col_q         <= '0;
			row_q         <= '0;
			xi_q          <= '0;
			yi_q          <= '0;
			bx_q          <= '0;
			by_q          <= '0;
			col_end_q     <= DIM_W'(nb_new);
			row_end_q     <= DIM_W'(nb_new);
			row_partial_q <= '0;
		end else if (accept) begin
			if (in_x && in_y)
				row_partial_q <= rp_next;
			priority if (last_x) begin
				col_q     <= '0;
				xi_q      <= '0;
				bx_q      <= '0;
				col_end_q <= DIM_W'(nb);
				priority if (last_y) begin
					row_q     <= '0;
					yi_q      <= '0;
					by_q      <= '0;
					row_end_q <= DIM_W'(nb);
				end else if (yi_last) begin
					row_q     <= row_q + ROW_W'(1);
					yi_q      <= '0;
					by_q      <= by_q + IDX_W'(1);
					row_end_q <= row_end_q + DIM_W'(nb);
				end else begin
					row_q <= row_q + ROW_W'(1);
					yi_q  <= yi_q + XI_W'(1);
				end
			end else if (xi_last) begin
				col_q     <= col_q + COL_W'(1);
				xi_q      <= '0;
				bx_q      <= bx_q + IDX_W'(1);
				col_end_q <= col_end_q + DIM_W'(nb);
			end else begin
				col_q <= col_q + COL_W'(1);
				xi_q  <= xi_q + XI_W'(1);
			end
		end
	end

	// line store: read at accept, write back as the add stage moves on
	always_ff @(posedge clk) begin
		if (accept && col_op)
			rd_s1 <= mem[bx_q[COL_W-1:0]];
		if (s1_go && s1_q.col_op)
			mem[s1_q.addr] <= acc;
	end

	always_comb begin
		base = fwd_s1 ? fwd_data_q : rd_s1;
		acc  = (s1_q.first_row ? '0 : base) + SUM_W'(s1_q.row_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			fwd_s1     <= col_op && s1_go && s1_q.col_op && s1_q.addr == bx_q[COL_W-1:0];
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.addr      <= bx_q[COL_W-1:0];
			s1_q.row_sum   <= rp_next;
			s1_q.col_op    <= col_op;
			s1_q.first_row <= yi_q == '0;
			s1_q.blk_done  <= blk_done;
			s1_q.last_blk  <= last_blk;
			s1_q.bx        <= bx_q;
			s1_q.by        <= by_q;
		end
		if (s1_go && s1_q.col_op)
			fwd_data_q <= acc;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go && s1_q.blk_done)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_q.blk_done) begin
			out_sum_q  <= acc;
			out_col_q  <= s1_q.bx;
			out_row_q  <= s1_q.by;
			out_last_q <= s1_q.last_blk;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-SUM_W-2*IDX_W){1'b0}}, out_row_q, out_col_q, out_sum_q};
	assign m_tlast  = out_last_q;

	a_fwd_col_op: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_valid_q && s1_q.col_op)
		else $error("forward flag without a line store access");

	a_blk_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && blk_done && !cfg_we) |=> s1_valid_q && s1_q.blk_done)
		else $error("completed block lost at add stage");

	a_bin_phase: assert property (@(posedge clk) disable iff (!arst_n)
		{{(NB_W-XI_W){1'b0}}, xi_q} < nb && {{(NB_W-XI_W){1'b0}}, yi_q} < nb)
		else $error("bin phase counter beyond bin factor");

endmodule

`default_nettype wire
